### hw/rtl/epm_pkg.sv
// Shared types, operation codes and arithmetic constants for the entropy pool mixer.
`default_nettype none

package epm_pkg;

    // Operation codes carried on the input channel.
    localparam logic [1:0] OP_FILL    = 2'd0;
    localparam logic [1:0] OP_MIX     = 2'd1;
    localparam logic [1:0] OP_EXTRACT = 2'd2;

    // Default geometry of the pool.
    localparam int POOL_DEPTH_DEF    = 1024;
    localparam int BATCH_SAMPLES_DEF = 16;
    localparam int SLOT_STRIDE_DEF   = 64;

    // FNV-1a 64 constants. The prime is 2^40 + 0x1b3, so a multiply by it is a
    // shift plus a narrow product.
    localparam logic [63:0] FNV_BASIS     = 64'hcbf2_9ce4_8422_2325;
    localparam logic [8:0]  FNV_PRIME_LO  = 9'h1b3;
    localparam int          FNV_PRIME_SH  = 40;

    // Linear congruential generator constants used by the seed fill.
    localparam logic [30:0] LCG_MUL = 31'd1103515245;
    localparam logic [13:0] LCG_ADD = 14'd12345;

    // Busy and done flags reported by the arithmetic units to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

`default_nettype wire

### hw/rtl/epm_pool_ram.sv
// Byte-wide pool memory with one write port and one registered read port.
`default_nettype none

module epm_pool_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: the data register holds its word until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/epm_fnv_unit.sv
// Iterative FNV-1a 64 hash of one 64-bit sample, one byte per cycle.
`default_nettype none

module epm_fnv_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [63:0]        i_sample,
    output epm_pkg::t_unit_stat     o_stat,
    output logic      [63:0]        o_hash
);

    import epm_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [2:0]  r_count;
    logic [63:0] r_hash;
    logic [63:0] r_sample;

    logic [63:0] w_mixed;
    logic [63:0] w_prod_lo;
    logic [63:0] n_hash;

    // One round: fold in the next byte, then multiply by the prime.
    assign w_mixed   = r_hash ^ {56'd0, r_sample[7:0]};
    assign w_prod_lo = w_mixed * FNV_PRIME_LO;
    assign n_hash    = (w_mixed << FNV_PRIME_SH) + w_prod_lo;

    // Control: eight rounds, then a single-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + 3'd1;
                if (r_count == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: hash and remaining sample bytes.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hash   <= FNV_BASIS;
            r_sample <= i_sample;
        end else if (r_busy) begin
            r_hash   <= n_hash;
            r_sample <= r_sample >> 8;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_hash      = r_hash;

endmodule

`default_nettype wire

### hw/rtl/epm_lcg_unit.sv
// Seed fill generator: steps the 64-bit LCG and writes one pool byte per generator step.
`default_nettype none

module epm_lcg_unit #(
    parameter int POOL_DEPTH = 1024,
    parameter int AW         = 10
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [63:0]     i_seed,
    output epm_pkg::t_unit_stat  o_stat,
    output logic                 o_we,
    output logic      [AW-1:0]   o_waddr,
    output logic      [7:0]      o_wdata
);

    import epm_pkg::*;

    logic          r_busy;
    logic          r_done;
    logic          r_phase;
    logic [AW-1:0] r_addr;
    logic [63:0]   r_seed;
    logic [62:0]   r_prod_lo;

    logic [62:0]   w_prod_lo;
    logic [31:0]   w_prod_hi;
    logic [63:0]   n_seed;

    // The 64 by 31 bit product is split into two 32 by 31 bit halves, one
    // per phase; only the low 32 bits of the upper half survive the wrap.
    assign w_prod_lo = r_seed[31:0] * LCG_MUL;
    assign w_prod_hi = r_seed[63:32] * LCG_MUL;
    assign n_seed    = {1'b0, r_prod_lo} + {w_prod_hi, 32'd0} + {50'd0, LCG_ADD};

    // Control: phase and address sequencing across the whole pool.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_addr  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_addr  <= '0;
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == AW'(POOL_DEPTH - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    // Datapath: low partial product, then the new generator state.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_seed <= i_seed;
        end else if (r_busy) begin
            if (r_phase) begin
                r_seed <= n_seed;
            end else begin
                r_prod_lo <= w_prod_lo;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_we        = r_busy & r_phase;
    assign o_waddr     = r_addr;
    assign o_wdata     = n_seed[31:24];

endmodule

`default_nettype wire

### hw/rtl/entropy_pool_mixer.sv
// Entropy pool mixer top level: sequencer, pointers, pool memory and output register.
// Usage: one input channel (i_in_valid / o_in_ready) carries a word made of an
// operation, a 64-bit value and a request index; one output channel
// (o_out_valid / i_out_ready) returns a random byte for each extract word.
// A word is accepted when valid and ready are both high at a rising edge.
// Seed fill occupies the block until every pool byte is written; the split LCG
// multiply gives each pool byte a multiply phase and a write phase. Mix runs
// the eight FNV rounds in the hash unit, hands the hash over, then streams
// nine reads and eight writes through the pool memory. Extract reads the pool
// memory and then loads its byte, through the registered memory read port, into
// the output register once that register is free. Operation code 3 is accepted and dropped.
// One word is processed at a time; o_in_ready is high whenever the
// sequencer is idle, also while a result waits in the output register.
// If the receiver stalls, a further extract holds its read data in the
// memory read register until the output register frees.
// Synchronous reset clears the pointers, the batch count and all control
// state; the pool contents are undefined until a seed fill.
`default_nettype none

module entropy_pool_mixer #(
    parameter int POOL_DEPTH    = epm_pkg::POOL_DEPTH_DEF,
    parameter int BATCH_SAMPLES = epm_pkg::BATCH_SAMPLES_DEF,
    parameter int SLOT_STRIDE   = epm_pkg::SLOT_STRIDE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [63:0] i_value,
    input  wire logic [9:0]  i_request_index,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [7:0]  o_random_byte
);

    import epm_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int BW = (BATCH_SAMPLES > 1) ? $clog2(BATCH_SAMPLES) : 1;

    localparam logic [AW-1:0] ADDR_ONE    = AW'(1);
    localparam logic [AW-1:0] STRIDE_INC  = AW'(SLOT_STRIDE);
    localparam logic [AW-1:0] BATCH_ADV   = AW'(BATCH_SAMPLES * 8);
    localparam logic [BW-1:0] BATCH_LAST  = BW'(BATCH_SAMPLES - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FILL   = 3'd1;
    localparam logic [2:0] ST_HASH   = 3'd2;
    localparam logic [2:0] ST_MIX    = 3'd3;
    localparam logic [2:0] ST_EX_RD  = 3'd4;
    localparam logic [2:0] ST_EX_OUT = 3'd5;

    // Steps of the mix pass through memory.
    localparam logic [3:0] MIX_LAST_READ   = 4'd8;
    localparam logic [3:0] MIX_FIRST_WRITE = 4'd2;
    localparam logic [3:0] MIX_LAST_STEP   = 4'd9;

    // Modular add of a value below the pool depth.
    function automatic logic [AW-1:0] f_wrap_add(input logic [AW-1:0] a,
                                                 input logic [AW-1:0] inc);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, inc};
        if (s >= (AW+1)'(POOL_DEPTH)) begin
            s = s - (AW+1)'(POOL_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [2:0]    r_state;
    logic [3:0]    r_step;
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW-1:0] r_slot_base;
    logic [BW-1:0] r_batch;
    logic [AW-1:0] r_mix_raddr;
    logic [AW-1:0] r_mix_waddr;
    logic [63:0]   r_mix_hash;
    logic [7:0]    r_prev;
    logic [63:0]   r_value;
    logic [2:0]    r_sel;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;

    logic          w_accept;
    logic          w_out_load;
    logic          w_fnv_start;
    logic          w_lcg_start;
    t_unit_stat    w_fnv_stat;
    t_unit_stat    w_lcg_stat;
    logic [63:0]   w_hash;
    logic          w_lcg_we;
    logic [AW-1:0] w_lcg_waddr;
    logic [7:0]    w_lcg_wdata;
    logic          w_mix_we;
    logic [7:0]    w_mix_wdata;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [7:0]    w_ram_wdata;
    logic          w_ram_re;
    logic [AW-1:0] w_ram_raddr;
    logic [7:0]    w_ram_rdata;
    logic [7:0]    w_ts_byte;

    // Handshake decode.
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid & o_in_ready;
    assign w_fnv_start = w_accept & (i_operation == OP_MIX);
    assign w_lcg_start = w_accept & (i_operation == OP_FILL);
    assign w_out_load  = (r_state == ST_EX_OUT) & (~r_out_valid | i_out_ready);

    // Mix pass: each pool byte takes its hash byte and its old right neighbour.
    assign w_mix_we    = (r_state == ST_MIX) & (r_step >= MIX_FIRST_WRITE);
    assign w_mix_wdata = r_prev ^ r_mix_hash[7:0] ^ w_ram_rdata;

    // Memory port selection.
    assign w_ram_we    = w_lcg_we | w_mix_we;
    assign w_ram_waddr = w_lcg_we ? w_lcg_waddr : r_mix_waddr;
    assign w_ram_wdata = w_lcg_we ? w_lcg_wdata : w_mix_wdata;
    assign w_ram_re    = ((r_state == ST_MIX) & (r_step <= MIX_LAST_READ)) |
                         (r_state == ST_EX_RD);
    assign w_ram_raddr = (r_state == ST_EX_RD) ? r_rd_ptr : r_mix_raddr;

    // Timestamp byte picked by the low bits of the request index.
    assign w_ts_byte = r_value[{r_sel, 3'b000} +: 8];

    // Sequencer and pointer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_slot_base <= '0;
            r_batch     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        unique case (i_operation)
                            OP_FILL:    r_state <= ST_FILL;
                            OP_MIX:     r_state <= ST_HASH;
                            OP_EXTRACT: r_state <= ST_EX_RD;
                            default:    r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_FILL: begin
                    if (w_lcg_stat.done) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_HASH: begin
                    if (w_fnv_stat.done) begin
                        r_step  <= '0;
                        r_state <= ST_MIX;
                    end
                end
                ST_MIX: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == MIX_LAST_STEP) begin
                        r_state <= ST_IDLE;
                        if (r_batch == BATCH_LAST) begin
                            r_batch     <= '0;
                            r_wr_ptr    <= f_wrap_add(r_wr_ptr, BATCH_ADV);
                            r_slot_base <= f_wrap_add(r_wr_ptr, BATCH_ADV);
                        end else begin
                            r_batch     <= r_batch + BW'(1);
                            r_slot_base <= f_wrap_add(r_slot_base, STRIDE_INC);
                        end
                    end
                end
                ST_EX_RD: begin
                    r_rd_ptr <= f_wrap_add(r_rd_ptr, ADDR_ONE);
                    r_state  <= ST_EX_OUT;
                end
                ST_EX_OUT: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Mix and extract working registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= i_value;
            r_sel   <= i_request_index[2:0];
        end
        if ((r_state == ST_HASH) && w_fnv_stat.done) begin
            r_mix_hash  <= w_hash;
            r_mix_raddr <= r_slot_base;
            r_mix_waddr <= r_slot_base;
        end
        if (r_state == ST_MIX) begin
            r_prev <= w_ram_rdata;
            if (r_step <= MIX_LAST_READ) begin
                r_mix_raddr <= f_wrap_add(r_mix_raddr, ADDR_ONE);
            end
            if (w_mix_we) begin
                r_mix_waddr <= f_wrap_add(r_mix_waddr, ADDR_ONE);
                r_mix_hash  <= r_mix_hash >> 8;
            end
        end
    end

    // Output register: a waiting word does not block new input.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_byte <= w_ram_rdata ^ w_ts_byte;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_random_byte = r_out_byte;

    // Hash unit.
    epm_fnv_unit u_fnv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_fnv_start),
        .i_sample (i_value),
        .o_stat   (w_fnv_stat),
        .o_hash   (w_hash)
    );

    // Seed fill generator.
    epm_lcg_unit #(
        .POOL_DEPTH (POOL_DEPTH),
        .AW         (AW)
    ) u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lcg_start),
        .i_seed  (i_value),
        .o_stat  (w_lcg_stat),
        .o_we    (w_lcg_we),
        .o_waddr (w_lcg_waddr),
        .o_wdata (w_lcg_wdata)
    );

    // Pool memory.
    epm_pool_ram #(
        .DEPTH (POOL_DEPTH),
        .AW    (AW)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule

`default_nettype wire
